[src/stlru_pkg.sv]
// Package for the session table: shared constants, widths and the compare-unit operation enum.
// No dependencies; imported by stlru_cmp and session_table_lru_evict_reap.
`default_nettype none
package stlru_pkg;
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_BITS_DEF  = 48;
    localparam int STAMP_BITS    = 32;
    localparam int AGE_BITS      = 32;
    localparam int BUDGET_BITS   = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam int SLOT_OUT_BITS = 6;
    localparam int ACTIVE_BITS   = 7;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_AGE     = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCAN_BUDGET = 1'b1;

    localparam logic KIND_GET  = 1'b0;
    localparam logic KIND_REAP = 1'b1;

    // Operation requested of the shared compare unit for one entry.
    typedef enum logic [1:0] {
        CMP_MATCH = 2'd0,
        CMP_OLDEST = 2'd1,
        CMP_AGE = 2'd2
    } t_cmp_op;
endpackage
`default_nettype wire

[src/stlru_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// No dependencies.
`default_nettype none
module stlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[src/stlru_cmp.sv]
// Shared compare unit: key match, oldest-stamp compare and signed age test.
// Depends on stlru_pkg.
`default_nettype none
module stlru_cmp
    import stlru_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire t_cmp_op                 i_op,
    input  wire logic [KEY_BITS-1:0]     i_entry_key,
    input  wire logic [KEY_BITS-1:0]     i_key,
    input  wire logic [STAMP_BITS-1:0]   i_entry_stamp,
    input  wire logic [STAMP_BITS-1:0]   i_ref,
    input  wire logic [AGE_BITS-1:0]     i_max_age,
    output logic                         o_true
);
    logic [STAMP_BITS-1:0] diff;

    always_comb begin
        diff = i_ref - i_entry_stamp;
        unique case (i_op)
            CMP_MATCH:  o_true = (i_entry_key == i_key);
            // Ties go to the later index, so less-or-equal replaces.
            CMP_OLDEST: o_true = (i_entry_stamp <= i_ref);
            // Positive age only, then unsigned compare against the limit.
            CMP_AGE:    o_true = !diff[STAMP_BITS-1] &&
                                 ({1'b0, diff[STAMP_BITS-2:0]} > i_max_age);
            default:    o_true = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

[src/session_table_lru_evict_reap.sv]
// Top level of the session table with oldest-first eviction and reaping.
// Depends on stlru_pkg, stlru_ram and stlru_cmp.
//
// Usage. Items arrive on the s_axis channel. Each transaction carries a kind bit in tuser
// and the client key and current time in tdata. A get item looks the key up and refreshes
// it on a hit. On a miss it allocates a slot from the free stack, or evicts the oldest
// session when the stack is empty. A reap item examines min(max(scan_budget,1),CAPACITY)
// slots from a wrapping cursor and frees the stale ones. Exactly one result transaction
// leaves on m_axis for each item.
// Operation. One item is handled at a time, and the walks read the key and stamp memories one
// entry per cycle through the single shared compare unit. After each item the block returns to
// idle before it accepts the next one.
// Reset clears the valid bits and the cursor, sets the free stack depth and its low-water mark
// to CAPACITY and loads the register defaults. Stack slots below the low-water mark are never
// read from memory; their contents follow from the index, so no clearing pass is needed.
// Stalls. The result sits in an output register. While the receiver holds tready low the
// block accepts one more item, works it out and holds it until the register is free.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data. The user must write it
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
module session_table_lru_evict_reap
    import stlru_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: client_key [KEY_BITS-1:0], now_seconds above it, zero padded.
    input  wire logic [((KEY_BITS+STAMP_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: kind.
    input  wire logic                       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // tdata: slot_index [5:0], was_hit [6], was_evicted [7], active_sessions [14:8].
    output logic [15:0]                     m_axis_tdata,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0]   i_cfg_data
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_OLD, S_ALLOC, S_REAP, S_OUT
    } t_state;

    t_state                r_state;
    logic [AGE_BITS-1:0]   r_max_age;
    logic [BUDGET_BITS-1:0] r_budget;
    logic                  r_valid [CAPACITY];
    logic [CW-1:0]         r_depth;
    logic [CW-1:0]         r_low;      // lowest stack depth reached since reset
    logic [AW-1:0]         r_cursor;
    logic [KEY_BITS-1:0]   r_key;
    logic [STAMP_BITS-1:0] r_now;
    logic                  r_kind;
    logic [CW-1:0]         r_cnt;      // entries issued to the memories
    logic [AW-1:0]         r_raddr;
    logic [AW-1:0]         r_chk;      // entry whose data is on the ram outputs
    logic                  r_chk_ok;
    logic [CW-1:0]         r_left;
    logic                  r_have;
    logic [STAMP_BITS-1:0] r_oldest;
    logic [AW-1:0]         r_slot;
    logic                  r_hit;
    logic                  r_evict;
    logic                  r_we;
    logic [AW-1:0]         r_waddr;
    logic                  r_wkey;
    logic [15:0]           r_odata;

    logic [KEY_BITS-1:0]   key_rd;
    logic [STAMP_BITS-1:0] stamp_rd;
    logic [AW-1:0]         stack_rd;
    logic                  stack_we;
    t_cmp_op               cmp_op;
    logic                  cmp_true;
    logic [STAMP_BITS-1:0] cmp_ref;
    logic [CW-1:0]         budget_n;
    logic [AW-1:0]         stack_top;
    logic [CW-1:0]         top_idx;
    logic [CW-1:0]         active;

    stlru_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk(i_clk), .i_we(r_we && r_wkey), .i_waddr(r_waddr), .i_wdata(r_key),
        .i_raddr(r_raddr), .o_rdata(key_rd)
    );
    stlru_ram #(.WIDTH(STAMP_BITS), .DEPTH(CAPACITY)) u_stamp_ram (
        .i_clk(i_clk), .i_we(r_we), .i_waddr(r_waddr), .i_wdata(r_now),
        .i_raddr(r_raddr), .o_rdata(stamp_rd)
    );
    // The free stack is read at its top continuously; the depth is steady during a lookup,
    // so the registered read data is ready by the time the lookup ends.
    stlru_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_stack_ram (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr(r_depth[AW-1:0]), .i_wdata(r_chk),
        .i_raddr(top_idx[AW-1:0]), .o_rdata(stack_rd)
    );

    always_comb begin
        unique case (r_state)
            S_OLD:   cmp_op = CMP_OLDEST;
            S_REAP:  cmp_op = CMP_AGE;
            default: cmp_op = CMP_MATCH;
        endcase
        cmp_ref = (r_state == S_OLD) ? r_oldest : r_now;
    end

    stlru_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
        .i_op(cmp_op), .i_entry_key(key_rd), .i_key(r_key),
        .i_entry_stamp(stamp_rd), .i_ref(cmp_ref), .i_max_age(r_max_age),
        .o_true(cmp_true)
    );

    always_comb begin
        if (r_budget == '0) begin
            budget_n = CW'(1);
        end else if ({16'd0, r_budget} >= 32'(CAPACITY)) begin
            budget_n = CW'(CAPACITY);
        end else begin
            budget_n = CW'(r_budget);
        end
        top_idx = r_depth - CW'(1);
        // Slots below the low-water mark were never written; their value follows from the index.
        if (top_idx >= r_low) begin
            stack_top = stack_rd;
        end else begin
            stack_top = AW'(CAPACITY - 1) - top_idx[AW-1:0];
        end
        active = CW'(CAPACITY) - r_depth;
        stack_we = (r_state == S_REAP) && r_chk_ok && r_valid[r_chk] && cmp_true &&
                   (r_depth < CW'(CAPACITY));
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_age <= AGE_BITS'(60);
            r_budget  <= BUDGET_BITS'(16);
            r_depth   <= CW'(CAPACITY);
            r_low     <= CW'(CAPACITY);
            r_cursor  <= '0;
            r_we      <= 1'b0;
            m_axis_tvalid <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAX_AGE:     r_max_age <= i_cfg_data;
                    REG_SCAN_BUDGET: r_budget  <= i_cfg_data[BUDGET_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_key   <= s_axis_tdata[KEY_BITS-1:0];
                        r_now   <= s_axis_tdata[KEY_BITS +: STAMP_BITS];
                        r_kind  <= s_axis_tuser;
                        r_hit   <= 1'b0;
                        r_evict <= 1'b0;
                        r_have  <= 1'b0;
                        r_slot  <= '0;
                        r_chk_ok <= 1'b0;
                        r_cnt   <= '0;
                        if (s_axis_tuser == KIND_REAP) begin
                            r_raddr <= r_cursor;
                            r_left  <= budget_n;
                            r_state <= S_REAP;
                        end else begin
                            r_raddr <= '0;
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    // One entry issued per cycle; its compare happens in the cycle after it is issued.
                    r_chk    <= r_raddr;
                    r_chk_ok <= (r_cnt < CW'(CAPACITY));
                    if (r_cnt < CW'(CAPACITY)) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_raddr <= r_raddr + AW'(1);
                    end
                    if (r_chk_ok && r_valid[r_chk] && cmp_true) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_chk;
                        r_waddr <= r_chk;
                        r_wkey  <= 1'b0;
                        r_we    <= 1'b1;
                        r_state <= S_OUT;
                    end else if (!r_chk_ok && r_cnt == CW'(CAPACITY)) begin
                        if (r_depth != '0) begin
                            r_slot  <= stack_top;
                            r_depth <= r_depth - CW'(1);
                            if (top_idx < r_low) begin
                                r_low <= top_idx;
                            end
                            r_state <= S_ALLOC;
                        end else begin
                            r_cnt   <= '0;
                            r_raddr <= '0;
                            r_state <= S_OLD;
                        end
                    end
                end
                S_OLD: begin
                    r_chk    <= r_raddr;
                    r_chk_ok <= (r_cnt < CW'(CAPACITY));
                    if (r_cnt < CW'(CAPACITY)) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_raddr <= r_raddr + AW'(1);
                    end
                    if (r_chk_ok && r_valid[r_chk] && (!r_have || cmp_true)) begin
                        r_have   <= 1'b1;
                        r_oldest <= stamp_rd;
                        r_slot   <= r_chk;
                    end
                    if (!r_chk_ok && r_cnt == CW'(CAPACITY)) begin
                        r_evict <= r_have;
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    r_valid[r_slot] <= 1'b1;
                    r_waddr <= r_slot;
                    r_wkey  <= 1'b1;
                    r_we    <= 1'b1;
                    r_state <= S_OUT;
                end
                S_REAP: begin
                    // Issue, then test the entry on the following cycle.
                    r_chk    <= r_raddr;
                    r_chk_ok <= (r_left != '0);
                    if (r_left != '0) begin
                        r_left   <= r_left - CW'(1);
                        r_raddr  <= (r_raddr == AW'(CAPACITY - 1)) ? '0 : r_raddr + AW'(1);
                        r_cursor <= (r_cursor == AW'(CAPACITY - 1)) ? '0 : r_cursor + AW'(1);
                    end
                    if (r_chk_ok && r_valid[r_chk] && cmp_true) begin
                        r_valid[r_chk] <= 1'b0;
                        // The freed slot goes onto the stack unless it is already full.
                        if (stack_we) begin
                            r_depth <= r_depth + CW'(1);
                        end
                    end
                    if (!r_chk_ok && r_left == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // The memory write issued on entry completes at the end of this cycle.
                    r_we <= 1'b0;
                    if (!m_axis_tvalid) begin
                        r_odata <= {1'b0, ACTIVE_BITS'(active), r_evict, r_hit,
                                    SLOT_OUT_BITS'(r_kind ? '0 : r_slot)};
                        m_axis_tvalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = r_odata;

    // The free stack depth never exceeds the capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_depth <= CW'(CAPACITY))
        else $error("free depth overflow");
    // A waiting result holds still until the receiver takes it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while waiting");
    // A result appears only after the sequencer passed through the output state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_OUT)
        else $error("result without sequencer");
endmodule
`default_nettype wire
